/* src/mpm_pkg.sv */
// shared types and constants for the multi-period measurement block
package mpm_pkg;

  localparam int unsigned PERIODS_W  = 8;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned TICKS_W    = 32;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  // one overflow spans 2**OVF_SHIFT ticks
  localparam int unsigned OVF_SHIFT  = 16;

  localparam logic [PERIODS_W-1:0] PERIODS_RESET = 8'd50;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIODS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b1;

  // request kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // result outcomes
  localparam logic OUTCOME_MEASURED  = 1'b0;
  localparam logic OUTCOME_NO_SIGNAL = 1'b1;

  typedef struct packed {
    logic kind;
    logic pin_level;
  } mpm_in_t;

  typedef struct packed {
    logic [TICKS_W-1:0] period_ticks;
    logic               outcome;
  } mpm_out_t;

endpackage

/* src/multi_period_measure.sv */
// top level of the multi-period measurement block
//
// usage:
// - in_* channel carries one request per cycle while in_ready: kind start arms
//   (or re-arms) a measurement, kind tick is one timer tick with a sample of the pin
// - after a start the block syncs on a low, then a high level; each sync wait
//   times out after timeout_overflows * 65536 ticks with a no-signal result
// - it then sums the ticks of periods_to_measure low-then-high cycles and
//   returns the saturated total on the out_* channel
// - throughput: one request per cycle while in_ready is high; all state updates
//   happen in one combinational pass ahead of the state and result registers
// - a result is registered in the result register, or in the skid register
// - a two-deep output stage (result register plus skid register) lets
//   requests keep flowing while a result waits; in_ready drops only when
//   both are full, so a stalled receiver backs up the input after two results
// - reset (synchronous, rst_n low) returns to idle with the register defaults
//   (50 periods, 10 overflows); ticks in idle are dropped. cfg_* is a plain
//   write port; the user writes it only while idle (the block does not check)
module multi_period_measure
  import mpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mpm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mpm_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SYNC_LOW  = 3'd1,
    PH_SYNC_HIGH = 3'd2,
    PH_MEAS_LOW  = 3'd3,
    PH_MEAS_HIGH = 3'd4
  } phase_t;

  // configuration registers
  logic [PERIODS_W-1:0] periods_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  // measurement state
  phase_t               phase_r,  phase_nxt;
  logic [TICKS_W-1:0]   ticks_r,  ticks_nxt;
  logic [PERIODS_W-1:0] done_r,   done_nxt;

  // output stage
  logic     out_valid_r, skid_valid_r;
  mpm_out_t out_data_r,  skid_data_r;

  logic                 in_fire;
  logic                 res_valid;
  mpm_out_t             res;
  logic [TICKS_W-1:0]   ticks_inc;
  logic [TICKS_W-1:0]   ticks_sat;
  logic [TICKS_W-1:0]   limit;
  logic [TIMEOUT_W-1:0] timeout_eff;
  logic [PERIODS_W-1:0] done_inc;
  logic                 take;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  // zero overflows behaves as one
  assign timeout_eff = (timeout_r == '0) ? TIMEOUT_W'(1) : timeout_r;
  assign limit       = TICKS_W'({timeout_eff, {OVF_SHIFT{1'b0}}});
  assign ticks_inc   = ticks_r + TICKS_W'(1);
  assign ticks_sat   = (ticks_r == '1) ? ticks_r : ticks_inc;
  assign done_inc    = done_r + PERIODS_W'(1);

  // one pass of the measurement for the accepted request
  always_comb begin
    phase_nxt        = phase_r;
    ticks_nxt        = ticks_r;
    done_nxt         = done_r;
    res_valid        = 1'b0;
    res.period_ticks = '0;
    res.outcome      = OUTCOME_MEASURED;
    if (in_data.kind == KIND_START) begin
      phase_nxt = PH_SYNC_LOW;
      ticks_nxt = '0;
      done_nxt  = '0;
    end else begin
      unique case (phase_r)
        PH_SYNC_LOW, PH_SYNC_HIGH: begin
          if (in_data.pin_level == (phase_r == PH_SYNC_HIGH)) begin
            // awaited level found, restart the count
            ticks_nxt = '0;
            if (phase_r == PH_SYNC_LOW) begin
              phase_nxt = PH_SYNC_HIGH;
            end else begin
              done_nxt = '0;
              if (periods_r == '0) begin
                // nothing to measure, report zero at once
                res_valid = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_MEAS_LOW;
              end
            end
          end else if (ticks_inc >= limit) begin
            // sync wait timed out
            ticks_nxt   = '0;
            res_valid   = 1'b1;
            res.outcome = OUTCOME_NO_SIGNAL;
            phase_nxt   = PH_IDLE;
          end else begin
            ticks_nxt = ticks_inc;
          end
        end
        PH_MEAS_LOW: begin
          ticks_nxt = ticks_sat;
          if (!in_data.pin_level) begin
            phase_nxt = PH_MEAS_HIGH;
          end
        end
        PH_MEAS_HIGH: begin
          ticks_nxt = ticks_sat;
          if (in_data.pin_level) begin
            // rising level closes one period
            done_nxt = done_inc;
            if (done_inc >= periods_r) begin
              res_valid        = 1'b1;
              res.period_ticks = ticks_sat;
              phase_nxt        = PH_IDLE;
            end else begin
              phase_nxt = PH_MEAS_LOW;
            end
          end
        end
        default: begin
          // idle and unused codes drop the tick
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periods_r <= PERIODS_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIODS: periods_r <= cfg_wdata[PERIODS_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // measurement state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ticks_r <= '0;
      done_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      done_r  <= done_nxt;
    end
  end

  // output register with skid stage
  assign take = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_r && !take) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* verif/mpm_result_checker.sv */
// result checker for the multi-period measurement block: predicts and compares
`timescale 1ns / 1ps

module mpm_result_checker
  import mpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  mpm_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  mpm_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    outstanding,
  output logic                  armed
);

  typedef enum logic [2:0] {
    MTR_IDLE,
    MTR_SYNC_LOW,
    MTR_SYNC_HIGH,
    MTR_MEAS_LOW,
    MTR_MEAS_HIGH
  } meter_phase_t;

  meter_phase_t           meter_phase;
  logic [TICKS_W-1:0]     tick_total;
  logic [PERIODS_W-1:0]   periods_done;
  logic [PERIODS_W-1:0]   periods_cfg;
  logic [TIMEOUT_W-1:0]   timeout_cfg;

  mpm_out_t expected_periods[$];

  // one accepted request through the meter; returns 1 when a result is due
  function automatic bit advance_meter(input mpm_in_t req, output mpm_out_t res);
    logic [TIMEOUT_W-1:0] ovf;
    logic [47:0]          limit;
    logic                 awaited;
    res = '0;
    if (req.kind == KIND_START) begin
      meter_phase  = MTR_SYNC_LOW;
      tick_total   = '0;
      periods_done = '0;
      return 1'b0;
    end
    case (meter_phase)
      MTR_SYNC_LOW, MTR_SYNC_HIGH: begin
        awaited = (meter_phase == MTR_SYNC_HIGH);
        if (req.pin_level == awaited) begin
          tick_total = '0;
          if (meter_phase == MTR_SYNC_LOW) begin
            meter_phase = MTR_SYNC_HIGH;
          end else begin
            periods_done = '0;
            if (periods_cfg == '0) begin
              res.outcome = OUTCOME_MEASURED;
              meter_phase = MTR_IDLE;
              return 1'b1;
            end
            meter_phase = MTR_MEAS_LOW;
          end
          return 1'b0;
        end
        tick_total = tick_total + 1'b1;
        // a zero timeout behaves as one overflow
        ovf   = (timeout_cfg == '0) ? TIMEOUT_W'(1) : timeout_cfg;
        limit = 48'(ovf) << OVF_SHIFT;
        if (48'(tick_total) >= limit) begin
          tick_total  = '0;
          res.outcome = OUTCOME_NO_SIGNAL;
          meter_phase = MTR_IDLE;
          return 1'b1;
        end
        return 1'b0;
      end
      MTR_MEAS_LOW, MTR_MEAS_HIGH: begin
        if (tick_total != '1) tick_total = tick_total + 1'b1;
        if (meter_phase == MTR_MEAS_LOW) begin
          if (!req.pin_level) meter_phase = MTR_MEAS_HIGH;
          return 1'b0;
        end
        if (req.pin_level) begin
          periods_done = periods_done + 1'b1;
          if (periods_done >= periods_cfg) begin
            res.period_ticks = tick_total;
            res.outcome      = OUTCOME_MEASURED;
            meter_phase      = MTR_IDLE;
            return 1'b1;
          end
          meter_phase = MTR_MEAS_LOW;
        end
        return 1'b0;
      end
      default: begin
        meter_phase = MTR_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    mpm_out_t got;
    mpm_out_t want;
    mpm_out_t pred;
    if (!rst_n) begin
      meter_phase  = MTR_IDLE;
      tick_total   = '0;
      periods_done = '0;
      periods_cfg  = PERIODS_RESET;
      timeout_cfg  = TIMEOUT_RESET;
      fail_count   = 0;
      expected_periods.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_periods.size() == 0) begin
          $error("unexpected result: period_ticks %0d outcome %0d",
                 got.period_ticks, got.outcome);
          fail_count = fail_count + 1;
        end else begin
          want = expected_periods.pop_front();
          if (got.period_ticks !== want.period_ticks) begin
            $error("period_ticks: expected %0d, actual %0d",
                   want.period_ticks, got.period_ticks);
            fail_count = fail_count + 1;
          end
          if (got.outcome !== want.outcome) begin
            $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIODS: periods_cfg = cfg_wdata[PERIODS_W-1:0];
          REG_TIMEOUT: timeout_cfg = cfg_wdata[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (advance_meter(in_data, pred)) expected_periods.push_back(pred);
      end
    end
    outstanding <= expected_periods.size();
    armed       <= (meter_phase != MTR_IDLE);
  end

endmodule

/* verif/tb_multi_period_measure.sv */
// testbench top for the multi-period measurement block: stimulus and verdict
`timescale 1ns / 1ps

module tb_multi_period_measure;
  import mpm_pkg::*;

  // total request count, directed part included
  localparam int TOTAL_REQUESTS = 1650;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  mpm_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  mpm_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int   fail_count;
  int   outstanding;
  logic armed;

  // request counter and sender jitter switch
  int sent;
  bit tx_jitter;

  multi_period_measure u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // watches both channels and the register port, predicts and compares
  mpm_result_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .armed       (armed)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // drop valid for the gap that n gives; n = 0 leaves valid untouched so that a
  // following request does not assign it twice in one step
  task automatic hold_off(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // random sender gap: mostly none or short, now and then long
  task automatic sender_pause();
    int n;
    n = 0;
    if (tx_jitter && $urandom_range(0, 3) == 0)
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 3);
    hold_off(n);
  endtask

  // one request, held until accepted, then maybe a gap
  task automatic request(input logic k, input logic p);
    in_valid <= 1'b1;
    in_data  <= mpm_in_t'{kind: k, pin_level: p};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent = sent + 1;
    sender_pause();
  endtask

  // both registers back to back, one write per cycle
  task automatic set_config(input logic [PERIODS_W-1:0] periods,
                            input logic [TIMEOUT_W-1:0] timeout);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PERIODS;
    cfg_wdata <= CFG_DATA_W'(periods);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(timeout);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // bring the block back to idle: feed low/high pairs while a measurement is
  // still armed, then wait for every expected result and the output latency
  task automatic finish_measurement();
    hold_off(1);
    while (armed) begin
      request(KIND_TICK, 1'b0);
      request(KIND_TICK, 1'b1);
      hold_off(1);
    end
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // well-formed measurement: start, a few highs while syncing on low, then
  // enough low/high cycles to finish, and some ignored ticks afterwards
  task automatic run_measurement(input int unsigned n_periods, input int unsigned max_len);
    request(KIND_START, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 2)) request(KIND_TICK, 1'b1);
    repeat (n_periods + 1) begin
      repeat ($urandom_range(1, max_len)) request(KIND_TICK, 1'b0);
      repeat ($urandom_range(1, max_len)) request(KIND_TICK, 1'b1);
    end
    repeat ($urandom_range(0, 2)) request(KIND_TICK, 1'($urandom_range(0, 1)));
  endtask

  // noise: random levels with an occasional start, often leaving a
  // measurement half done so the next start restarts it
  task automatic run_noise();
    repeat ($urandom_range(4, 24))
      request(($urandom_range(0, 7) == 0) ? KIND_START : KIND_TICK,
              1'($urandom_range(0, 1)));
  endtask

  // receiver: ready runs and stalls of random length, long now and then,
  // plus long stretches with no stall at all
  initial begin : receiver
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
      repeat (n) @(posedge clk);
      out_ready <= 1'b0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      repeat (n) @(posedge clk);
    end
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("tb_multi_period_measure failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned periods;
    int unsigned max_len;
    int unsigned waited;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PERIODS;
    cfg_wdata <= '0;
    sent      = 0;
    tx_jitter = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ticks while idle are dropped
    request(KIND_TICK, 1'b0);
    request(KIND_TICK, 1'b1);

    // reset defaults: fifty periods of one low and one high tick
    run_measurement(PERIODS_RESET, 1);
    finish_measurement();

    // single period, walk through every phase by hand
    set_config(8'd1, 16'd2);
    request(KIND_START, 1'b1);
    request(KIND_TICK, 1'b1);   // still waiting for low
    request(KIND_TICK, 1'b0);   // low found, now wait for high
    request(KIND_TICK, 1'b0);
    request(KIND_TICK, 1'b1);   // high found, measuring starts
    request(KIND_TICK, 1'b1);
    request(KIND_TICK, 1'b0);
    request(KIND_TICK, 1'b0);
    request(KIND_TICK, 1'b1);   // period done, result
    // start while busy restarts from the wait for low
    request(KIND_START, 1'b0);
    request(KIND_TICK, 1'b0);
    request(KIND_START, 1'b1);
    request(KIND_TICK, 1'b0);
    request(KIND_TICK, 1'b1);
    request(KIND_TICK, 1'b0);
    request(KIND_TICK, 1'b1);
    finish_measurement();

    // zero periods: result of zero as soon as the high level is found
    set_config(8'd0, 16'd3);
    request(KIND_START, 1'b0);
    request(KIND_TICK, 1'b0);
    request(KIND_TICK, 1'b1);
    finish_measurement();

    // largest settings: most periods, longest timeout
    tx_jitter = 1'b1;
    set_config(8'd255, 16'hFFFF);
    run_measurement(255, 2);
    finish_measurement();

    // random phases: new settings each time, mostly clean measurements
    while (sent < TOTAL_REQUESTS) begin
      finish_measurement();
      periods   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      max_len   = $urandom_range(1, 5);
      tx_jitter = ($urandom_range(0, 3) != 0);
      set_config(PERIODS_W'(periods), TIMEOUT_W'($urandom_range(0, 65535)));
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 3) != 0) run_measurement(periods, max_len);
        else run_noise();
      end
    end

    // drain: every expected result, then the output latency
    hold_off(1);
    waited = 0;
    while (outstanding != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    if (outstanding != 0) $error("results never arrived: %0d", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_multi_period_measure passed");
    end else begin
      $display("tb_multi_period_measure failed");
    end
    $finish;
  end

endmodule
